// ===== rtl/http_request_line_parser_macros.svh =====
// Assertion macros for the HTTP request line parser.
// Included by the top level; depends on nothing else.
`ifndef HTTP_REQUEST_LINE_PARSER_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_MACROS_SVH

// Same-cycle implication.
`define HRLP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrlp: same-cycle check failed");

// Next-cycle implication.
`define HRLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrlp: next-cycle check failed");

`endif

// ===== rtl/hrlp_pkg.sv =====
// Shared types, character constants and name tables for the request line parser.
// Used by every module of the block; depends on nothing.
package hrlp_pkg;

   localparam int MAX_LINE_DEFAULT = 8192;
   localparam int FIELD_W          = 13;

   localparam int QUEUE_DEPTH = 2;   // power of two
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // Names padded to eight characters; only positions below the length count.
   // Index 0 is OPTIONS, index 7 is CONNECT.
   localparam logic [7:0][63:0] METHOD_NAMES = {
      "CONNECT ", "TRACE   ", "DELETE  ", "PUT     ",
      "POST    ", "HEAD    ", "GET     ", "OPTIONS "
   };
   localparam logic [7:0][3:0] METHOD_LENS = {
      4'd7, 4'd5, 4'd6, 4'd3, 4'd4, 4'd4, 4'd3, 4'd7
   };
   localparam int VERSION_LEN = 8;
   localparam logic [1:0][63:0] VERSION_NAMES = {"HTTP/1.1", "HTTP/1.0"};

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_METHOD_LONG    = 3'd1,
      ST_METHOD_UNKNOWN = 3'd2,
      ST_PATH_BAD       = 3'd3,
      ST_VERSION_LONG   = 3'd4,
      ST_VERSION_BAD    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      PH_METHOD,
      PH_PATH_START,
      PH_PATH,
      PH_VERSION,
      PH_DISCARD
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
      logic       is_space;
      logic       is_cr;
   } word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic pop;
      logic load;
   } back_status_type;

   // Character at position pos of a left-aligned eight-character name.
   function automatic logic [7:0] name_byte(logic [63:0] name, logic [2:0] pos);
      logic [5:0] lsb;
      lsb = {3'd7 - pos, 3'b000};
      return name[lsb +: 8];
   endfunction

endpackage

// ===== rtl/hrlp_front.sv =====
// Input stage: takes request line bytes and tags spaces, carriage returns.
// Depends on hrlp_pkg.
module hrlp_front
   import hrlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   output logic       word_valid,
   output word_type   word,
   input  logic       word_ready
);

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;
   logic     accept;

   assign req_ready = !valid_ff || word_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      word_in.data_byte = req_data_byte;
      word_in.is_last   = req_is_last;
      word_in.is_space  = (req_data_byte == CH_SPACE);
      word_in.is_cr     = (req_data_byte == CH_CR);
      if (accept) begin
         valid_in = 1'b1;
      end else if (word_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

// ===== rtl/hrlp_queue.sv =====
// Short FIFO between the classifying front and the parsing back end.
// Depends on hrlp_pkg.
module hrlp_queue
   import hrlp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  word_type         in_word,
   output logic             out_valid,
   output word_type         out_word,
   input  logic             pop,
   output queue_status_type status
);

   word_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 push;

   assign status.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign in_ready     = !status.full;
   assign push         = in_valid && in_ready;
   assign out_valid    = !status.empty;
   assign out_word     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_word;
      end
   end

endmodule

// ===== rtl/hrlp_back.sv =====
// Parser back end: phase machine, name matchers, counters and result register.
// Depends on hrlp_pkg.
module hrlp_back
   import hrlp_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                word_valid,
   input  word_type            word,
   output back_status_type     status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output logic [2:0]          rsp_method_code,
   output logic                rsp_method_known,
   output logic                rsp_path_found,
   output logic [FIELD_W-1:0]  rsp_path_offset,
   output logic [FIELD_W-1:0]  rsp_path_length
);

   localparam int               LINE_W   = $clog2(MAX_LINE);
   localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(MAX_LINE - 1);

   phase_type         phase_ff, phase_in;
   logic [3:0]        token_count_ff, token_count_in;
   logic [7:0]        method_alive_ff, method_alive_in;
   logic [1:0]        version_alive_ff, version_alive_in;
   logic [LINE_W-1:0] byte_offset_ff, byte_offset_in;
   logic [LINE_W-1:0] path_begin_ff, path_begin_in;
   logic [LINE_W-1:0] path_count_ff, path_count_in;
   logic [2:0]        decoded_ff, decoded_in;
   logic              method_valid_ff, method_valid_in;
   logic              path_seen_ff, path_seen_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, verdict;
   logic [2:0]         rsp_method_ff;
   logic               rsp_known_ff, rsp_found_ff;
   logic [FIELD_W-1:0] rsp_offset_ff, rsp_length_ff;

   logic pop, verdict_hit, matched, result, restart;

   function automatic logic [LINE_W-1:0] sat_inc(logic [LINE_W-1:0] v);
      return (v < LINE_MAX) ? v + LINE_W'(1) : LINE_MAX;
   endfunction

   assign pop     = word_valid && (!rsp_valid_ff || rsp_ready);
   assign result  = pop && (phase_ff != PH_DISCARD) && (verdict_hit || word.is_last);
   assign restart = pop && word.is_last;

   // Datapath and verdict for the word at the queue head.
   always_comb begin
      token_count_in   = token_count_ff;
      method_alive_in  = method_alive_ff;
      version_alive_in = version_alive_ff;
      path_begin_in    = path_begin_ff;
      path_count_in    = path_count_ff;
      decoded_in       = decoded_ff;
      method_valid_in  = method_valid_ff;
      path_seen_in     = path_seen_ff;
      byte_offset_in   = sat_inc(byte_offset_ff);
      verdict_hit      = 1'b0;
      verdict          = ST_OK;
      matched          = 1'b0;
      unique case (phase_ff)
         PH_METHOD: begin
            if (!word.is_space) begin
               for (int m = 0; m < 8; m++) begin
                  method_alive_in[m] = method_alive_ff[m]
                     && (token_count_ff[2:0] < METHOD_LENS[m][2:0])
                     && (name_byte(METHOD_NAMES[m], token_count_ff[2:0]) == word.data_byte);
               end
               token_count_in = token_count_ff + 4'd1;
               if (token_count_in > 4'd7) begin
                  verdict_hit = 1'b1;
                  verdict     = ST_METHOD_LONG;
               end
            end else begin
               verdict_hit = 1'b1;
               verdict     = ST_METHOD_UNKNOWN;
               // Lowest code wins; the names differ, so at most one matches.
               for (int m = 7; m >= 0; m--) begin
                  if (method_alive_ff[m] && (METHOD_LENS[m] == token_count_ff)) begin
                     decoded_in      = 3'(m);
                     method_valid_in = 1'b1;
                     matched         = 1'b1;
                     verdict_hit     = 1'b0;
                  end
               end
            end
         end
         PH_PATH_START: begin
            if (word.is_space || word.is_cr) begin
               verdict_hit = 1'b1;
               verdict     = ST_PATH_BAD;
            end else begin
               path_begin_in = byte_offset_ff;
               path_count_in = LINE_W'(1);
               path_seen_in  = 1'b1;
            end
         end
         PH_PATH: begin
            if (word.is_space) begin
               token_count_in   = 4'd0;
               version_alive_in = 2'b11;
            end else begin
               path_count_in = sat_inc(path_count_ff);
            end
         end
         PH_VERSION: begin
            if (!word.is_cr) begin
               for (int k = 0; k < 2; k++) begin
                  version_alive_in[k] = version_alive_ff[k] && !token_count_ff[3]
                     && (name_byte(VERSION_NAMES[k], token_count_ff[2:0]) == word.data_byte);
               end
               token_count_in = token_count_ff + 4'd1;
               if (token_count_in > 4'(VERSION_LEN)) begin
                  verdict_hit = 1'b1;
                  verdict     = ST_VERSION_LONG;
               end
            end else begin
               verdict_hit = 1'b1;
               verdict = ((token_count_ff == 4'(VERSION_LEN)) && (|version_alive_ff))
                  ? ST_OK : ST_VERSION_BAD;
            end
         end
         PH_DISCARD: begin
            byte_offset_in = byte_offset_ff;
         end
         default: begin
            byte_offset_in = byte_offset_ff;
         end
      endcase
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (pop) begin
         priority if (word.is_last) begin
            phase_in = PH_METHOD;
         end else if (phase_ff == PH_DISCARD) begin
            phase_in = PH_DISCARD;
         end else if (verdict_hit) begin
            phase_in = PH_DISCARD;
         end else begin
            unique case (phase_ff)
               PH_METHOD:     phase_in = matched ? PH_PATH_START : PH_METHOD;
               PH_PATH_START: phase_in = PH_PATH;
               PH_PATH:       phase_in = word.is_space ? PH_VERSION : PH_PATH;
               PH_VERSION:    phase_in = PH_VERSION;
               default:       phase_in = PH_METHOD;
            endcase
         end
      end
   end

   always_comb begin
      if (result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         token_count_ff   <= '0;
         method_alive_ff  <= '1;
         version_alive_ff <= '1;
         byte_offset_ff   <= '0;
         path_begin_ff    <= '0;
         path_count_ff    <= '0;
         decoded_ff       <= '0;
         method_valid_ff  <= 1'b0;
         path_seen_ff     <= 1'b0;
      end else if (pop) begin
         token_count_ff   <= token_count_in;
         method_alive_ff  <= method_alive_in;
         version_alive_ff <= version_alive_in;
         byte_offset_ff   <= byte_offset_in;
         path_begin_ff    <= path_begin_in;
         path_count_ff    <= path_count_in;
         decoded_ff       <= decoded_in;
         method_valid_ff  <= method_valid_in;
         path_seen_ff     <= path_seen_in;
      end
      if (reset) begin
         phase_ff     <= PH_METHOD;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (result) begin
         rsp_status_ff <= verdict_hit ? verdict : ST_OK;
         rsp_method_ff <= method_valid_in ? decoded_in : 3'd0;
         rsp_known_ff  <= method_valid_in;
         rsp_found_ff  <= path_seen_in;
         rsp_offset_ff <= path_seen_in ? FIELD_W'(path_begin_in) : '0;
         rsp_length_ff <= path_seen_in ? FIELD_W'(path_count_in) : '0;
      end
   end

   assign status.pop  = pop;
   assign status.load = result;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_method_code  = rsp_method_ff;
   assign rsp_method_known = rsp_known_ff;
   assign rsp_path_found   = rsp_found_ff;
   assign rsp_path_offset  = rsp_offset_ff;
   assign rsp_path_length  = rsp_length_ff;

endmodule

// ===== rtl/http_request_line_parser.sv =====
// Top level of the HTTP request line parser: front stage, queue, parser back end.
// Depends on hrlp_pkg, hrlp_front, hrlp_queue, hrlp_back and the macro header.
//
//   channel  | direction | handshake           | word
//   ---------+-----------+---------------------+---------------------------------------
//   req_     | in        | req_valid/req_ready | data_byte, is_last
//   rsp_     | out       | rsp_valid/rsp_ready | status, method_code, method_known,
//            |           |                     | path_found, path_offset, path_length
//
// One byte per cycle is taken and parsed unless the rsp_ side stalls; the phase machine
// in the back end settles each byte in one update, so the rate is set by that update.
// A result is registered in the back end after its byte passes the front and the queue.
// Reset is synchronous and clears the phase, counters and all valid flags.
// A stalled rsp_ side holds the back end; the two-entry queue and the front
// register keep taking bytes until they fill, so each side stalls on its own.
`include "http_request_line_parser_macros.svh"

module http_request_line_parser
   import hrlp_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [2:0]         rsp_method_code,
   output logic               rsp_method_known,
   output logic               rsp_path_found,
   output logic [FIELD_W-1:0] rsp_path_offset,
   output logic [FIELD_W-1:0] rsp_path_length
);

   logic             front_valid, q_ready, q_valid;
   word_type         front_word, q_word;
   queue_status_type q_status;
   back_status_type  back_status;

   // Classify each byte and register it.
   hrlp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_is_last   (req_is_last),
      .word_valid    (front_valid),
      .word          (front_word),
      .word_ready    (q_ready)
   );

   // Decouple the front from the parser.
   hrlp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (q_ready),
      .in_word   (front_word),
      .out_valid (q_valid),
      .out_word  (q_word),
      .pop       (back_status.pop),
      .status    (q_status)
   );

   // Advance the phase machine and register results.
   hrlp_back #(
      .MAX_LINE (MAX_LINE)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .word_valid       (q_valid),
      .word             (q_word),
      .status           (back_status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_method_code  (rsp_method_code),
      .rsp_method_known (rsp_method_known),
      .rsp_path_found   (rsp_path_found),
      .rsp_path_offset  (rsp_path_offset),
      .rsp_path_length  (rsp_path_length)
   );

   // The back end never drains an empty queue.
   `HRLP_ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, back_status.pop, !q_status.empty)
   // A result is only ever made from a byte taken off the queue.
   `HRLP_ASSERT_IMPLIES(a_load_needs_pop, clock, reset, back_status.load, back_status.pop)
   // An accepted byte lands in the front register.
   `HRLP_ASSERT_NEXT(a_accept_fills_front, clock, reset, req_valid && req_ready, front_valid)
   // Reset drops any pending result.
   `HRLP_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)

endmodule

// ===== bench/hrlp_tb_pkg.sv =====
// Line scoreboard for the HTTP request line parser bench: byte-level predictor
// and the queue of expected results. Depends on hrlp_pkg for status codes and widths.
package hrlp_tb_pkg;
   import hrlp_pkg::*;

   typedef enum logic [1:0] {
      PS_METHOD,
      PS_PATH_START,
      PS_PATH,
      PS_VERSION
   } parse_stage_type;

   typedef struct packed {
      status_type         status;
      logic [2:0]         method_code;
      logic               method_known;
      logic               path_found;
      logic [FIELD_W-1:0] path_offset;
      logic [FIELD_W-1:0] path_length;
   } line_result_type;

   localparam int unsigned OFFSET_MAX = MAX_LINE_DEFAULT - 1;

   // Method text by code: OPTIONS 0 through CONNECT 7.
   function automatic string method_name(int unsigned code);
      case (code)
         0: return "OPTIONS";
         1: return "GET";
         2: return "HEAD";
         3: return "POST";
         4: return "PUT";
         5: return "DELETE";
         6: return "TRACE";
         default: return "CONNECT";
      endcase
   endfunction

   class line_scoreboard;
      line_result_type want_q[$];

      parse_stage_type stage;
      logic [7:0]   tok[8];
      int unsigned  tok_len;
      int unsigned  offset;
      int unsigned  path_start;
      int unsigned  path_bytes;
      int unsigned  method_idx;
      bit           method_seen;
      bit           path_seen;
      bit           done;

      int unsigned  mismatches;
      int unsigned  parsed_bytes;
      int unsigned  ok_lines;
      int unsigned  error_lines;

      function new();
         clear();
      endfunction

      function void clear();
         stage       = PS_METHOD;
         tok_len     = 0;
         offset      = 0;
         path_start  = 0;
         path_bytes  = 0;
         method_idx  = 0;
         method_seen = 0;
         path_seen   = 0;
         done        = 0;
      endfunction

      function int unsigned pending();
         return want_q.size();
      endfunction

      function void put_char(logic [7:0] c);
         if (tok_len < 8) begin
            tok[tok_len] = c;
         end
         tok_len++;
      endfunction

      // Only positions below tok_len are read, so stale entries never matter.
      function bit token_is(string s);
         if (tok_len != s.len()) return 0;
         for (int i = 0; i < s.len(); i++) begin
            if (tok[i] != s[i]) return 0;
         end
         return 1;
      endfunction

      function int unsigned sat(int unsigned v);
         return (v < OFFSET_MAX) ? v + 1 : OFFSET_MAX;
      endfunction

      // Advance the parse by one accepted byte and queue the result it yields.
      function void note_byte(logic [7:0] c, logic last);
         status_type      verdict;
         bit              ruled;
         line_result_type r;
         if (done) begin
            if (last) clear();
            return;
         end
         parsed_bytes++;
         ruled   = 0;
         verdict = ST_OK;
         case (stage)
            PS_METHOD: begin
               if (c != CH_SPACE) begin
                  put_char(c);
                  if (tok_len > 7) begin
                     ruled   = 1;
                     verdict = ST_METHOD_LONG;
                  end
               end else begin
                  ruled   = 1;
                  verdict = ST_METHOD_UNKNOWN;
                  for (int m = 0; m < 8 && ruled; m++) begin
                     if (token_is(method_name(m))) begin
                        method_idx  = m;
                        method_seen = 1;
                        stage       = PS_PATH_START;
                        ruled       = 0;
                     end
                  end
               end
            end
            PS_PATH_START: begin
               if (c == CH_SPACE || c == CH_CR) begin
                  ruled   = 1;
                  verdict = ST_PATH_BAD;
               end else begin
                  path_start = offset;
                  path_bytes = 1;
                  path_seen  = 1;
                  stage      = PS_PATH;
               end
            end
            PS_PATH: begin
               if (c == CH_SPACE) begin
                  tok_len = 0;
                  stage   = PS_VERSION;
               end else begin
                  path_bytes = sat(path_bytes);
               end
            end
            default: begin
               ruled = 1;
               if (c != CH_CR) begin
                  put_char(c);
                  ruled   = (tok_len > 8);
                  verdict = ST_VERSION_LONG;
               end else if (token_is("HTTP/1.0") || token_is("HTTP/1.1")) begin
                  verdict = ST_OK;
               end else begin
                  verdict = ST_VERSION_BAD;
               end
            end
         endcase
         offset = sat(offset);
         if (!ruled && !last) return;
         // End of input without a verdict reports success.
         if (!ruled) verdict = ST_OK;

         r.status       = verdict;
         r.method_code  = method_seen ? 3'(method_idx) : 3'd0;
         r.method_known = method_seen;
         r.path_found   = path_seen;
         r.path_offset  = path_seen ? FIELD_W'(path_start) : '0;
         r.path_length  = path_seen ? FIELD_W'(path_bytes) : '0;
         want_q.push_back(r);
         if (verdict == ST_OK) ok_lines++;
         else error_lines++;
         if (last) clear();
         else done = 1;
      endfunction

      function void flag(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [2:0] status, logic [2:0] method_code,
                                 logic method_known, logic path_found,
                                 logic [FIELD_W-1:0] path_offset,
                                 logic [FIELD_W-1:0] path_length);
         line_result_type w;
         if (want_q.size() == 0) begin
            $display("%0t: result expected none, got status %0d offset %0d length %0d",
                     $time, status, path_offset, path_length);
            mismatches++;
            return;
         end
         w = want_q.pop_front();
         flag("status", FIELD_W'(w.status), FIELD_W'(status));
         flag("method_code", FIELD_W'(w.method_code), FIELD_W'(method_code));
         flag("method_known", FIELD_W'(w.method_known), FIELD_W'(method_known));
         flag("path_found", FIELD_W'(w.path_found), FIELD_W'(path_found));
         flag("path_offset", w.path_offset, path_offset);
         flag("path_length", w.path_length, path_length);
      endfunction
   endclass

endpackage

// ===== bench/tb_top.sv =====
// Top of the request line parser bench: clock, reset, byte driver and result monitor.
// Depends on hrlp_pkg, hrlp_tb_pkg and the http_request_line_parser RTL.
module tb_top;
   import hrlp_pkg::*;
   import hrlp_tb_pkg::*;

   // Bytes that the parser actually looks at, per traffic pattern.
   localparam int PHASE_BYTES = 360;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_data_byte;
   logic               req_is_last;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [2:0]         rsp_status;
   logic [2:0]         rsp_method_code;
   logic               rsp_method_known;
   logic               rsp_path_found;
   logic [FIELD_W-1:0] rsp_path_offset;
   logic [FIELD_W-1:0] rsp_path_length;

   // Pending request line: {is_last, data_byte} per entry.
   logic [8:0]     line_q[$];
   int             send_idle_pct  = 0;
   int             recv_stall_pct = 0;
   int unsigned    line_count     = 0;
   line_scoreboard sb;

   http_request_line_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_method_code  (rsp_method_code),
      .rsp_method_known (rsp_method_known),
      .rsp_path_found   (rsp_path_found),
      .rsp_path_offset  (rsp_path_offset),
      .rsp_path_length  (rsp_path_length)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops a result.
   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Result side: check each word taken, then pick next cycle's ready.
   // Signals read here hold their values from just before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_status, rsp_method_code, rsp_method_known,
                         rsp_path_found, rsp_path_offset, rsp_path_length);
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         line_q.push_back({1'b0, s[i]});
      end
   endfunction

   function automatic logic [7:0] pick_byte_except(logic [7:0] a, logic [7:0] b);
      logic [7:0] c;
      c = 8'($urandom_range(255));
      while (c == a || c == b) c = 8'($urandom_range(255));
      return c;
   endfunction

   // Path: first byte may be neither space nor CR, the rest only not space.
   function automatic void put_path(int len);
      line_q.push_back({1'b0, pick_byte_except(CH_SPACE, CH_CR)});
      for (int i = 1; i < len; i++) begin
         line_q.push_back({1'b0, pick_byte_except(CH_SPACE, CH_SPACE)});
      end
   endfunction

   // Send the pending line word by word; mark its final byte as the last one.
   // Raise valid and hold it with the payload until ready is seen at an edge.
   task automatic send_line();
      logic [8:0] w;
      line_q[line_q.size() - 1][8] = 1'b1;
      while (line_q.size() != 0) begin
         w = line_q.pop_front();
         if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
         end
         req_valid     <= 1'b1;
         req_data_byte <= w[7:0];
         req_is_last   <= w[8];
         do @(posedge clock); while (!req_ready);
         sb.note_byte(w[7:0], w[8]);
      end
      line_count++;
   endtask

   // One random request line. Most are well formed with random content; the
   // rest are cut short, corrupted, carry bad tokens, or are plain noise.
   task automatic random_line();
      int kind;
      int cut;
      int pos;
      kind = $urandom_range(99);
      if (kind >= 95) begin
         repeat ($urandom_range(1, 20)) line_q.push_back({1'b0, 8'($urandom)});
      end else begin
         if (kind >= 80 && kind < 85) begin
            // Made-up method, possibly empty or too long.
            repeat ($urandom_range(0, 9)) line_q.push_back({1'b0, 8'("A" + $urandom_range(25))});
         end else begin
            put_text(method_name($urandom_range(7)));
         end
         line_q.push_back({1'b0, CH_SPACE});
         if (kind >= 90) begin
            line_q.push_back({1'b0, ($urandom_range(1) != 0) ? CH_SPACE : CH_CR});
         end
         put_path(($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12));
         line_q.push_back({1'b0, CH_SPACE});
         if (kind >= 85 && kind < 90) begin
            case ($urandom_range(3))
               0: put_text("HTTP/1.2");
               1: put_text("HTTP/2.0");
               2: put_text("HTTP/1.10");
               default: put_text("HTTP/1");
            endcase
         end else begin
            put_text(($urandom_range(1) != 0) ? "HTTP/1.1" : "HTTP/1.0");
         end
         line_q.push_back({1'b0, CH_CR});
         // Trailing bytes after the verdict get discarded up to the last one.
         if ($urandom_range(1) != 0) begin
            put_text("\n");
            repeat ($urandom_range(0, 6)) line_q.push_back({1'b0, 8'($urandom)});
         end
         if (kind >= 60 && kind < 70) begin
            cut = $urandom_range(1, line_q.size());
            while (line_q.size() > cut) void'(line_q.pop_back());
         end
         if (kind >= 70 && kind < 80) begin
            pos = $urandom_range(line_q.size() - 1);
            line_q[pos][7:0] = 8'($urandom);
         end
      end
      send_line();
   endtask

   initial begin
      int unsigned target;
      sb = new();
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= 8'h00;
      req_is_last   <= 1'b0;
      rsp_ready     <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero and all-ones bytes in the path, verdict on the last byte.
      put_text("PUT ");
      line_q.push_back({1'b0, 8'h00});
      line_q.push_back({1'b0, 8'hFF});
      put_text(" HTTP/1.1");
      line_q.push_back({1'b0, CH_CR});
      send_line();
      // Method too long, ruled on the last byte.
      put_text("CONNECTS");
      send_line();
      // Input ends before any verdict.
      put_text("GE");
      send_line();

      // Random lines under four traffic patterns.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 17 : 0;
         recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 17 : 0;
         target = sb.parsed_bytes + PHASE_BYTES;
         while (sb.parsed_bytes < target) random_line();
      end
      req_valid <= 1'b0;

      // Drain: wait for every queued result, then keep the clock running so any
      // stray word still shows up. The hard stop covers a hang here.
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Ran %0d request lines, %0d bytes parsed, over four idle/stall patterns",
               line_count, sb.parsed_bytes);
      $display("Results checked: %0d accepted lines, %0d rejected lines",
               sb.ok_lines, sb.error_lines);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
